// ===== rtl/core/trpl_pkg.sv =====
`timescale 1ns / 1ps
package trpl_pkg;

	localparam int SAT_BITS    = 16;
	localparam int FRAC_BITS   = 30;
	localparam int LOG_BITS    = 16;
	localparam int DIV_STAGES  = FRAC_BITS;
	localparam int NORM_STAGE  = DIV_STAGES + 1;
	localparam int LOG_LAST    = NORM_STAGE + LOG_BITS;
	localparam int T_STAGE     = LOG_LAST + 1;
	localparam int EXP_LAST    = T_STAGE + LOG_BITS;
	localparam int POW_STAGE   = EXP_LAST + 1;
	localparam int LANE_STAGES = POW_STAGE + 1;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_BITS     = 48;

	localparam logic [CFG_IDX_BITS-1:0] REG_RESIDUAL_A_B    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RESIDUAL_C_PAIR = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENTS_ABC   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ENDPOINT_A_C    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ENDPOINT_B_PAIR = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SAL_THRESHOLD   = 3'd5;

	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_END  = 2'd1,
		CLS_MID  = 2'd2
	} cls_t;

	typedef struct packed {
		logic [SAT_BITS-1:0] sat_a;
		logic [SAT_BITS-1:0] sat_b;
		logic [SAT_BITS-1:0] salinity;
	} in_beat_t;

	typedef struct packed {
		logic [SAT_BITS-1:0] perm_a;
		logic [SAT_BITS-1:0] perm_b;
		logic [SAT_BITS-1:0] perm_c;
		logic                bad_denominator;
	} out_beat_t;

	// Everything one phase carries down its lane; dead fields drop out in synthesis.
	typedef struct packed {
		cls_t                  cls;
		logic                  bad;
		logic [SAT_BITS-1:0]   endp;
		logic [15:0]           xp;
		logic [SAT_BITS:0]     den;
		logic [SAT_BITS:0]     rem;
		logic [FRAC_BITS-1:0]  q;
		logic [FRAC_BITS:0]    m;
		logic [4:0]            ipart;
		logic [LOG_BITS-1:0]   fr;
		logic [24:0]           t;
		logic [FRAC_BITS:0]    r;
		logic                  zse;
		logic [SAT_BITS-1:0]   perm;
	} lane_t;

	// Elaboration only: integer square root.
	function automatic logic [63:0] trpl_isqrt(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] root;
		logic [63:0] bit_w;
		v = v_in;
		root = '0;
		bit_w = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (bit_w > v) bit_w = bit_w >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (bit_w != 0) begin
				if (v >= root + bit_w) begin
					v = v - (root + bit_w);
					root = (root >> 1) + bit_w;
				end else begin
					root = root >> 1;
				end
				bit_w = bit_w >> 2;
			end
		end
		return root;
	endfunction

	// Elaboration only: 2^(-2^-k) in Q0.30 by repeated square roots.
	function automatic logic [63:0] trpl_c(input int k);
		logic [63:0] c;
		c = 64'd1 << 29;
		for (int i = 1; i <= 16; i++) begin
			if (i <= k) c = trpl_isqrt(c << 30);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/trpl_lane.sv =====
`timescale 1ns / 1ps
module trpl_lane
	import trpl_pkg::*;
(
	input  logic                   clk,
	input  logic [LANE_STAGES-1:0] en,
	input  lane_t                  op,
	output lane_t                  res
);

	lane_t st_s [LANE_STAGES+1];
	lane_t nx_w [1:LANE_STAGES];

	assign st_s[0] = op;

	for (genvar k = 1; k <= LANE_STAGES; k++) begin : g_st
		if (k <= DIV_STAGES) begin : g_div
			// restoring divide, one quotient bit per stage
			logic [SAT_BITS+1:0] r2;
			logic [SAT_BITS+1:0] d2;
			always_comb begin
				nx_w[k] = st_s[k-1];
				r2 = {st_s[k-1].rem, 1'b0};
				d2 = {1'b0, st_s[k-1].den};
				if (r2 >= d2) begin
					nx_w[k].rem = SAT_BITS'(0) + (SAT_BITS+1)'(r2 - d2);
					nx_w[k].q   = {st_s[k-1].q[FRAC_BITS-2:0], 1'b1};
				end else begin
					nx_w[k].rem = r2[SAT_BITS:0];
					nx_w[k].q   = {st_s[k-1].q[FRAC_BITS-2:0], 1'b0};
				end
			end
		end else if (k == NORM_STAGE) begin : g_norm
			logic [4:0] p;
			logic [4:0] sh;
			always_comb begin
				nx_w[k] = st_s[k-1];
				p = '0;
				for (int i = 0; i < FRAC_BITS; i++) begin
					if (st_s[k-1].q[i]) p = 5'(i);
				end
				sh = 5'(FRAC_BITS) - p;
				nx_w[k].zse   = (st_s[k-1].q == '0);
				nx_w[k].m     = {1'b0, st_s[k-1].q} << sh;
				nx_w[k].ipart = sh;
				nx_w[k].fr    = '0;
			end
		end else if (k <= LOG_LAST) begin : g_log
			// one fraction bit of log2 per squaring
			logic [2*FRAC_BITS+1:0] sq;
			logic [FRAC_BITS+1:0]   mm;
			always_comb begin
				nx_w[k] = st_s[k-1];
				sq = (2*FRAC_BITS+2)'(st_s[k-1].m) * (2*FRAC_BITS+2)'(st_s[k-1].m);
				mm = sq[2*FRAC_BITS+1:FRAC_BITS];
				if (mm[FRAC_BITS+1]) begin
					nx_w[k].m  = mm[FRAC_BITS+1:1];
					nx_w[k].fr = {st_s[k-1].fr[LOG_BITS-2:0], 1'b1};
				end else begin
					nx_w[k].m  = mm[FRAC_BITS:0];
					nx_w[k].fr = {st_s[k-1].fr[LOG_BITS-2:0], 1'b0};
				end
			end
		end else if (k == T_STAGE) begin : g_t
			logic [20:0] nlog;
			logic [36:0] tp;
			always_comb begin
				nx_w[k] = st_s[k-1];
				nlog = {st_s[k-1].ipart, 16'd0} - 21'(st_s[k-1].fr);
				tp   = 37'(st_s[k-1].xp) * 37'(nlog);
				nx_w[k].t = tp[36:12];
				nx_w[k].r = (FRAC_BITS+1)'(1) << FRAC_BITS;
			end
		end else if (k <= EXP_LAST) begin : g_exp
			localparam int TB = EXP_LAST - k;
			localparam logic [FRAC_BITS-1:0] CK = FRAC_BITS'(trpl_c(k - T_STAGE));
			logic [2*FRAC_BITS:0] pr;
			always_comb begin
				nx_w[k] = st_s[k-1];
				pr = (2*FRAC_BITS+1)'(st_s[k-1].r) * (2*FRAC_BITS+1)'(CK);
				if (st_s[k-1].t[TB]) nx_w[k].r = pr[2*FRAC_BITS:FRAC_BITS];
			end
		end else if (k == POW_STAGE) begin : g_pow
			logic [8:0] n;
			always_comb begin
				nx_w[k] = st_s[k-1];
				n = st_s[k-1].t[24:16];
				if (st_s[k-1].xp == '0) begin
					nx_w[k].r = (FRAC_BITS+1)'(1) << FRAC_BITS;
				end else if (st_s[k-1].zse || n >= 9'd31) begin
					nx_w[k].r = '0;
				end else begin
					nx_w[k].r = st_s[k-1].r >> n[4:0];
				end
			end
		end else begin : g_out
			logic [SAT_BITS+FRAC_BITS:0] ep;
			always_comb begin
				nx_w[k] = st_s[k-1];
				ep = (SAT_BITS+FRAC_BITS+1)'(st_s[k-1].endp) *
					(SAT_BITS+FRAC_BITS+1)'(st_s[k-1].r);
				case (st_s[k-1].cls)
					CLS_ZERO: nx_w[k].perm = '0;
					CLS_END:  nx_w[k].perm = st_s[k-1].endp;
					CLS_MID:  nx_w[k].perm = ep[SAT_BITS+FRAC_BITS-1:FRAC_BITS];
					default:  nx_w[k].perm = '0;
				endcase
			end
		end

		always_ff @(posedge clk) begin
			if (en[k-1]) st_s[k] <= nx_w[k];
		end
	end

	assign res = st_s[LANE_STAGES];

endmodule

// ===== rtl/core/three_phase_relperm_power_law_core.sv =====
`timescale 1ns / 1ps
// Three-phase power-law relative permeability, one cell or face per beat.
// Phase c saturation is 1 - sat_a - sat_b (signed; an oversum zeroes phase c).
// Salinity at or below the threshold picks the low-salinity residual c and
// endpoint b. Each phase is zero at or below its residual, its endpoint at or
// above its upper limit, else endpoint * Se^exponent with Se from a 30-stage
// one-bit-per-stage divider, log2 from 16 squaring stages and 2^-t from 16
// product stages, in one input stage plus 66 lane stages. A new beat enters
// every cycle unless out_ready stalls a full chain, and every stage has its
// own ready, so empty stages fill even while a result waits at the output.
// Configuration writes complete when offered and are meant for an idle block.
module three_phase_relperm_power_law_core
	import trpl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  in_beat_t                in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output out_beat_t               out_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	localparam logic signed [19:0] ONE20 = 20'sd65536;

	// configuration registers
	logic [31:0] res_ab_q;
	logic [31:0] res_c_q;
	logic [47:0] exp_q;
	logic [31:0] end_ac_q;
	logic [31:0] end_b_q;
	logic [15:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ab_q <= '0;
			res_c_q  <= '0;
			exp_q    <= 48'h2000_2000_2000;
			end_ac_q <= '1;
			end_b_q  <= '1;
			thr_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RESIDUAL_A_B:    res_ab_q <= cfg_data[31:0];
				REG_RESIDUAL_C_PAIR: res_c_q  <= cfg_data[31:0];
				REG_EXPONENTS_ABC:   exp_q    <= cfg_data;
				REG_ENDPOINT_A_C:    end_ac_q <= cfg_data[31:0];
				REG_ENDPOINT_B_PAIR: end_b_q  <= cfg_data[31:0];
				REG_SAL_THRESHOLD:   thr_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// stage-wise ready: a stage moves when empty or when the next one moves
	logic [LANE_STAGES:0] vld_s;
	logic [LANE_STAGES:0] en_w;

	assign en_w[LANE_STAGES] = !vld_s[LANE_STAGES] || out_ready;
	for (genvar k = 0; k < LANE_STAGES; k++) begin : g_en
		assign en_w[k] = !vld_s[k] || en_w[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en_w[0]) vld_s[0] <= in_valid;
			for (int k = 1; k <= LANE_STAGES; k++) begin
				if (en_w[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign in_ready  = en_w[0];
	assign out_valid = vld_s[LANE_STAGES];

	// input stage: salinity select, phase c saturation, branch per phase
	logic              low_w;
	logic [15:0]       rc_w;
	logic [15:0]       eb_w;
	logic signed [19:0] sa_w, sb_w, sc_w;
	logic signed [19:0] ra_w, rb_w, rcs_w;
	logic signed [19:0] den_w, up_a_w, up_b_w, up_c_w;
	logic signed [19:0] da_w, db_w, dc_w;
	lane_t             op_a_w, op_b_w, op_c_w;
	lane_t             op_a_s1, op_b_s1, op_c_s1;
	logic              bad_w;

	always_comb begin
		low_w  = in_data.salinity <= thr_q;
		rc_w   = low_w ? res_c_q[15:0] : res_c_q[31:16];
		eb_w   = low_w ? end_b_q[15:0] : end_b_q[31:16];
		sa_w   = signed'({4'b0, in_data.sat_a});
		sb_w   = signed'({4'b0, in_data.sat_b});
		ra_w   = signed'({4'b0, res_ab_q[15:0]});
		rb_w   = signed'({4'b0, res_ab_q[31:16]});
		rcs_w  = signed'({4'b0, rc_w});
		sc_w   = ONE20 - sa_w - sb_w;
		den_w  = ONE20 - ra_w - rb_w - rcs_w;
		up_a_w = ONE20 - rb_w - rcs_w;
		up_b_w = ONE20 - ra_w - rcs_w;
		up_c_w = ONE20 - ra_w - rb_w;
		da_w   = sa_w - ra_w;
		db_w   = sb_w - rb_w;
		dc_w   = sc_w - rcs_w;
		bad_w  = den_w <= 20'sd0;

		op_a_w = '0;
		op_b_w = '0;
		op_c_w = '0;
		op_a_w.bad  = bad_w;
		op_b_w.bad  = bad_w;
		op_c_w.bad  = bad_w;
		op_a_w.den  = den_w[16:0];
		op_b_w.den  = den_w[16:0];
		op_c_w.den  = den_w[16:0];
		op_a_w.rem  = da_w[16:0];
		op_b_w.rem  = db_w[16:0];
		op_c_w.rem  = dc_w[16:0];
		op_a_w.endp = end_ac_q[15:0];
		op_b_w.endp = eb_w;
		op_c_w.endp = end_ac_q[31:16];
		op_a_w.xp   = exp_q[15:0];
		op_b_w.xp   = exp_q[31:16];
		op_c_w.xp   = exp_q[47:32];
		op_a_w.cls  = (sa_w <= ra_w) ? CLS_ZERO : (sa_w >= up_a_w) ? CLS_END : CLS_MID;
		op_b_w.cls  = (sb_w <= rb_w) ? CLS_ZERO : (sb_w >= up_b_w) ? CLS_END : CLS_MID;
		op_c_w.cls  = (sc_w <= rcs_w) ? CLS_ZERO : (sc_w >= up_c_w) ? CLS_END : CLS_MID;
	end

	always_ff @(posedge clk) begin
		if (en_w[0]) begin
			op_a_s1 <= op_a_w;
			op_b_s1 <= op_b_w;
			op_c_s1 <= op_c_w;
		end
	end

	lane_t res_a_w, res_b_w, res_c_w;

	trpl_lane u_lane_a (
		.clk (clk),
		.en  (en_w[LANE_STAGES:1]),
		.op  (op_a_s1),
		.res (res_a_w)
	);

	trpl_lane u_lane_b (
		.clk (clk),
		.en  (en_w[LANE_STAGES:1]),
		.op  (op_b_s1),
		.res (res_b_w)
	);

	trpl_lane u_lane_c (
		.clk (clk),
		.en  (en_w[LANE_STAGES:1]),
		.op  (op_c_s1),
		.res (res_c_w)
	);

	assign out_data.perm_a          = res_a_w.perm;
	assign out_data.perm_b          = res_b_w.perm;
	assign out_data.perm_c          = res_c_w.perm;
	assign out_data.bad_denominator = res_a_w.bad;

	// a free output must open the whole chain back to the input
	a_chain_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("ready chain blocked with output free");

	// input held off only behind an occupied first stage
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s[0])
		else $error("input stalled with empty first stage");

	// no divide may be needed when the residual sum reaches one
	a_bad_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && op_a_s1.bad |->
			op_a_s1.cls != CLS_MID && op_b_s1.cls != CLS_MID && op_c_s1.cls != CLS_MID)
		else $error("interior phase with non-positive denominator");

endmodule
